// ----- rtl/block_mean_variance_stddev_top_macros.svh -----
// assertion helpers shared by the rtl files
`ifndef BLOCK_MEAN_VARIANCE_STDDEV_TOP_MACROS_SVH
`define BLOCK_MEAN_VARIANCE_STDDEV_TOP_MACROS_SVH

// same-cycle implication, sampled on the rising clock edge
`define BMVS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on the rising clock edge
`define BMVS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/bmvs_pkg.sv -----
package bmvs_pkg;

    // fixed field widths
    localparam int SAMPLE_BITS     = 16;
    localparam int VAR_BITS        = 31;
    localparam int STD_BITS        = 16;
    localparam int MAX_SAMPLES_DEF = 1024;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_SINGLE = 2'd1,
        ST_OVER   = 2'd2
    } status_t;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_FLUSH,
        S_MUL,
        S_DIFF,
        S_MEAN_GO,
        S_MEAN_WAIT,
        S_VAR_GO,
        S_VAR_WAIT,
        S_ROOT_GO,
        S_ROOT_WAIT,
        S_OUT
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic acc;
        logic mul;
        logic diff;
        logic mean_go;
        logic var_go;
        logic root_go;
        logic save_mean;
        logic save_var;
        logic emit;
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic div_done;
        logic root_done;
        logic single;
    } dp_stat_t;

endpackage

// ----- rtl/bmvs_div.sv -----
module bmvs_div #(
    parameter int DVD_W = 52,
    parameter int DVS_W = 22
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int CW = $clog2(DVD_W + 1);

    logic [CW-1:0]    cnt_reg;
    logic             run_reg;
    logic             done_reg;
    logic [DVD_W-1:0] quo_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVS_W:0]   rem_sh;
    logic [DVS_W:0]   trial;
    logic             ge;

    // one restoring step: shift in the next dividend bit and try the subtract
    assign rem_sh = {rem_reg, quo_reg[DVD_W-1]};
    assign trial  = rem_sh - {1'b0, dvs_reg};
    assign ge     = !trial[DVS_W];

    // step counter and done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CW'(DVD_W);
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (run_reg)
        begin
            cnt_reg  <= cnt_reg - CW'(1);
            run_reg  <= (cnt_reg != CW'(1));
            done_reg <= (cnt_reg == CW'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // quotient and partial remainder
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (run_reg)
        begin
            quo_reg <= {quo_reg[DVD_W-2:0], ge};
            rem_reg <= ge ? trial[DVS_W-1:0] : rem_sh[DVS_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- rtl/bmvs_sqrt.sv -----
module bmvs_sqrt #(
    parameter int ROOT_W = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [2*ROOT_W-1:0] radicand,
    output logic                done,
    output logic [ROOT_W-1:0]   root
);

    localparam int CW    = $clog2(ROOT_W + 1);
    localparam int RAD_W = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 2;

    logic [CW-1:0]    cnt_reg;
    logic             run_reg;
    logic             done_reg;
    logic [RAD_W-1:0] rad_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [REM_W-1:0] rem_reg;
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] tryv;
    logic [REM_W:0]   diff;
    logic             ge;

    // one root bit per step: bring down two radicand bits, test 4*root+1
    assign rem_sh = {rem_reg[ROOT_W-1:0], rad_reg[RAD_W-1 -: 2]};
    assign tryv   = {root_reg, 2'b01};
    assign diff   = {1'b0, rem_sh} - {1'b0, tryv};
    assign ge     = !diff[REM_W];

    // step counter and done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CW'(ROOT_W);
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (run_reg)
        begin
            cnt_reg  <= cnt_reg - CW'(1);
            run_reg  <= (cnt_reg != CW'(1));
            done_reg <= (cnt_reg == CW'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // radicand shifter, remainder and root
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (run_reg)
        begin
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            rem_reg  <= ge ? diff[REM_W-1:0] : rem_sh;
            root_reg <= {root_reg[ROOT_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ----- rtl/bmvs_dp.sv -----
`include "block_mean_variance_stddev_top_macros.svh"

module bmvs_dp #(
    parameter int MAX_SAMPLES = bmvs_pkg::MAX_SAMPLES_DEF,
    localparam int CNT_W = $clog2(MAX_SAMPLES + 1)
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  bmvs_pkg::dp_cmd_t                      cmd,
    output bmvs_pkg::dp_stat_t                     stat,
    input  logic signed [bmvs_pkg::SAMPLE_BITS-1:0] sample,
    output logic signed [bmvs_pkg::SAMPLE_BITS-1:0] mean,
    output logic [bmvs_pkg::VAR_BITS-1:0]          variance,
    output logic [bmvs_pkg::STD_BITS-1:0]          std_dev,
    output logic [CNT_W-1:0]                       count,
    output logic [1:0]                             status
);

    import bmvs_pkg::*;

    localparam int SB    = SAMPLE_BITS;
    localparam int SUM_W = SB + CNT_W;
    localparam int SQ_W  = 2 * SB - 2 + CNT_W;
    localparam int LO_W  = (SQ_W + 1) / 2;
    localparam int HI_W  = SQ_W - LO_W;
    localparam int DVD_W = 2 * SB + 2 * CNT_W - 2;
    localparam int DVS_W = 2 * CNT_W;
    localparam int RAD_W = 2 * STD_BITS;
    localparam int CHK_W = RAD_W + 2;
    localparam int PRD_W = DVD_W + DVS_W + 1;

    logic signed [SUM_W-1:0]   sum_reg;
    logic [SQ_W-1:0]           sumsq_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic                      ovf_reg;
    logic                      pend_vld_reg;
    logic [2*SB-2:0]           sq_pend_reg;
    logic signed [2*SB-1:0]    sq_full;
    logic                      full;
    logic [CNT_W+LO_W-1:0]     plo_reg;
    logic [CNT_W+HI_W-1:0]     phi_reg;
    logic signed [2*SUM_W-1:0] sum_sq;
    logic [DVD_W-1:0]          ssq_reg;
    logic [DVS_W-1:0]          nn_reg;
    logic [DVD_W-1:0]          d_reg;
    logic [DVD_W-1:0]          mean_num_reg;
    logic                      div_start;
    logic                      div_done;
    logic [DVD_W-1:0]          div_dvd;
    logic [DVS_W-1:0]          div_dvs;
    logic [DVD_W-1:0]          div_quo;
    logic signed [SB-1:0]      mean_reg;
    logic [VAR_BITS-1:0]       var_reg;
    logic                      root_done;
    logic [STD_BITS-1:0]       root;
    status_t                   st_code;

    assign full    = (cnt_reg == CNT_W'(MAX_SAMPLES));
    assign sq_full = (2*SB)'(sample) * (2*SB)'(sample);
    assign sum_sq  = (2*SUM_W)'(sum_reg) * (2*SUM_W)'(sum_reg);

    // accumulators: running sum and count at once, squares through sq_pend_reg
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg      <= '0;
            sumsq_reg    <= '0;
            cnt_reg      <= '0;
            ovf_reg      <= 1'b0;
            pend_vld_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            sum_reg      <= '0;
            sumsq_reg    <= '0;
            cnt_reg      <= '0;
            ovf_reg      <= 1'b0;
            pend_vld_reg <= 1'b0;
        end
        else
        begin
            pend_vld_reg <= cmd.acc && !full;
            if (cmd.acc && !full)
            begin
                sum_reg <= sum_reg + SUM_W'(sample);
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (cmd.acc && full)
            begin
                ovf_reg <= 1'b1;
            end
            if (pend_vld_reg)
            begin
                sumsq_reg <= sumsq_reg + SQ_W'(sq_pend_reg);
            end
        end
    end

    // square of the accepted sample
    always_ff @(posedge clk)
    begin
        if (cmd.acc)
        begin
            sq_pend_reg <= sq_full[2*SB-2:0];
        end
    end

    // end of block: products, then the numerators
    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            plo_reg      <= (CNT_W+LO_W)'(cnt_reg) * (CNT_W+LO_W)'(sumsq_reg[LO_W-1:0]);
            phi_reg      <= (CNT_W+HI_W)'(cnt_reg) * (CNT_W+HI_W)'(sumsq_reg[SQ_W-1:LO_W]);
            ssq_reg      <= sum_sq[DVD_W-1:0];
            nn_reg       <= DVS_W'(cnt_reg) * (DVS_W'(cnt_reg) - DVS_W'(1));
            // 2*sum + n, offset by 2n * half range so it stays positive
            mean_num_reg <= (DVD_W'(sum_reg) << 1) + DVD_W'(cnt_reg)
                            + (DVD_W'(cnt_reg) << SB);
        end
        if (cmd.diff)
        begin
            // n*sumsq - sum^2
            d_reg <= (DVD_W'(phi_reg) << LO_W) + DVD_W'(plo_reg) - ssq_reg;
        end
    end

    // shared divider: mean first, then variance unless the block holds a single sample
    assign div_start = cmd.mean_go | cmd.var_go;
    assign div_dvd   = cmd.var_go ? d_reg : mean_num_reg;
    assign div_dvs   = cmd.var_go ? nn_reg : (DVS_W'(cnt_reg) << 1);

    bmvs_div #(
        .DVD_W (DVD_W),
        .DVS_W (DVS_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_quo)
    );

    // result registers; the mean drops the half-range offset
    always_ff @(posedge clk)
    begin
        if (cmd.diff)
        begin
            var_reg <= '0;
        end
        else if (cmd.save_var)
        begin
            var_reg <= div_quo[VAR_BITS-1:0];
        end
        if (cmd.save_mean)
        begin
            mean_reg <= {~div_quo[SB-1], div_quo[SB-2:0]};
        end
    end

    bmvs_sqrt #(
        .ROOT_W (STD_BITS)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.root_go),
        .radicand (RAD_W'(var_reg)),
        .done     (root_done),
        .root     (root)
    );

    // status code
    always_comb
    begin
        if (cnt_reg == CNT_W'(1))
        begin
            st_code = ST_SINGLE;
        end
        else if (ovf_reg)
        begin
            st_code = ST_OVER;
        end
        else
        begin
            st_code = ST_OK;
        end
    end

    assign stat.div_done  = div_done;
    assign stat.root_done = root_done;
    assign stat.single    = (cnt_reg == CNT_W'(1));

    assign mean     = mean_reg;
    assign variance = var_reg;
    assign std_dev  = root;
    assign count    = cnt_reg;
    assign status   = st_code;

    // root is the floor square root of the variance
    `BMVS_ASSERT_IMP(a_root_floor, clk, rst_n, root_done, (CHK_W'(root) * CHK_W'(root) <= CHK_W'(var_reg)) && ((CHK_W'(root) + CHK_W'(1)) * (CHK_W'(root) + CHK_W'(1)) > CHK_W'(var_reg)), "root is not the floor square root")
    // variance quotient brackets the numerator
    `BMVS_ASSERT_IMP(a_var_quot, clk, rst_n, cmd.save_var, (PRD_W'(div_quo) * PRD_W'(nn_reg) <= PRD_W'(d_reg)) && ((PRD_W'(div_quo) + PRD_W'(1)) * PRD_W'(nn_reg) > PRD_W'(d_reg)), "variance quotient out of range")

endmodule

// ----- rtl/bmvs_ctrl.sv -----
`include "block_mean_variance_stddev_top_macros.svh"

module bmvs_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               last,
    output logic               busy,
    output logic               valid,
    output bmvs_pkg::dp_cmd_t  cmd,
    input  bmvs_pkg::dp_stat_t stat
);

    import bmvs_pkg::*;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.acc = start;
                if (start && last)
                begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_DIFF;
            end
            S_DIFF:
            begin
                cmd.diff   = 1'b1;
                state_next = S_MEAN_GO;
            end
            S_MEAN_GO:
            begin
                cmd.mean_go = 1'b1;
                state_next  = S_MEAN_WAIT;
            end
            S_MEAN_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.save_mean = 1'b1;
                    state_next    = stat.single ? S_ROOT_GO : S_VAR_GO;
                end
            end
            S_VAR_GO:
            begin
                cmd.var_go = 1'b1;
                state_next = S_VAR_WAIT;
            end
            S_VAR_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.save_var = 1'b1;
                    state_next   = S_ROOT_GO;
                end
            end
            S_ROOT_GO:
            begin
                cmd.root_go = 1'b1;
                state_next  = S_ROOT_WAIT;
            end
            S_ROOT_WAIT:
            begin
                if (stat.root_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                cmd.emit   = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy  = (state_reg != S_IDLE);
    assign valid = (state_reg == S_OUT);

    // a final beat always starts the result sequence
    `BMVS_ASSERT_NXT(a_last_busy, clk, rst_n, start && !busy && last, busy, "final beat did not start the result sequence")
    // after the result strobe the block is free again
    `BMVS_ASSERT_NXT(a_strobe_idle, clk, rst_n, valid, !busy && !valid, "block not idle after result strobe")
    // the divider only finishes while it is waited for
    `BMVS_ASSERT_IMP(a_div_waited, clk, rst_n, stat.div_done, state_reg == S_MEAN_WAIT || state_reg == S_VAR_WAIT, "divider finished outside a wait state")

endmodule

// ----- rtl/block_mean_variance_stddev_top.sv -----
// Block mean, variance and standard deviation of signed Q1.15 samples.
// Input: a sample beat is taken on a rising edge with start high and busy low;
// last marks the final sample of a block. Non-final beats are taken one per
// cycle, busy stays low while a block streams in.
// Output: on the final beat the block raises busy and, later, shows mean,
// variance (Q1.30, over N-1), std_dev (floor root, Q1.15), count and status
// for exactly one cycle with valid high. The receiver cannot hold results off.
// After the final beat the block forms the products and numerators, runs the
// shared restoring divider for the mean and then the variance, takes the
// square root and shows the result. The divider works on a dividend of
// W = 2*16 + 2*ceil(log2(MAX_SAMPLES+1)) - 2 bits (52 at MAX_SAMPLES = 1024)
// and gives one quotient bit per cycle; a single-sample block skips the
// variance divide. The square root takes one root bit per cycle.
// busy drops with the result beat, so the next block's first beat can be
// taken on the following edge.
// Samples beyond MAX_SAMPLES are dropped and flagged with status 2.
// Reset (rst_n low, asynchronous) clears the sums, the count and the
// controller; the next sample opens a new block.
module block_mean_variance_stddev_top #(
    parameter int MAX_SAMPLES = bmvs_pkg::MAX_SAMPLES_DEF,
    localparam int CNT_W = $clog2(MAX_SAMPLES + 1)
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    output logic                                    busy,
    input  logic signed [bmvs_pkg::SAMPLE_BITS-1:0] sample,
    input  logic                                    last,
    output logic                                    valid,
    output logic signed [bmvs_pkg::SAMPLE_BITS-1:0] mean,
    output logic [bmvs_pkg::VAR_BITS-1:0]           variance,
    output logic [bmvs_pkg::STD_BITS-1:0]           std_dev,
    output logic [CNT_W-1:0]                        count,
    output logic [1:0]                              status
);

    import bmvs_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequencer
    bmvs_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .last  (last),
        .busy  (busy),
        .valid (valid),
        .cmd   (cmd),
        .stat  (stat)
    );

    // accumulators, divider and root
    bmvs_dp #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .sample   (sample),
        .mean     (mean),
        .variance (variance),
        .std_dev  (std_dev),
        .count    (count),
        .status   (status)
    );

endmodule

// ----- tb/sv/block_mean_variance_stddev_top_tb.sv -----
`timescale 1ns / 100ps

module block_mean_variance_stddev_top_tb;

    import bmvs_pkg::*;

    localparam int MAX_BLOCK   = bmvs_pkg::MAX_SAMPLES_DEF;
    localparam int CNT_W       = $clog2(MAX_BLOCK + 1);
    localparam int RANDOM_BEATS = 500;
    // idle margin waited after the last expected result
    localparam int DRAIN_CYCLES = 2 * 130 + 26 + 40;

    // one block result as the receiver sees it
    typedef struct {
        logic signed [SAMPLE_BITS-1:0] mean;
        logic [VAR_BITS-1:0]           variance;
        logic [STD_BITS-1:0]           std_dev;
        logic [CNT_W-1:0]              count;
        status_t                       status;
    } block_stats_t;

    logic                          clk;
    logic                          rst_n;
    logic                          start;
    logic                          busy;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last;
    logic                          valid;
    logic signed [SAMPLE_BITS-1:0] mean;
    logic [VAR_BITS-1:0]           variance;
    logic [STD_BITS-1:0]           std_dev;
    logic [CNT_W-1:0]              count;
    logic [1:0]                    status;

    // running block accumulators of the predictor
    longint       blk_sum;
    longint       blk_sqsum;
    int           blk_n;
    bit           blk_over;

    block_stats_t pending_stats[$];
    int           err_count;
    bit           steady;

    block_mean_variance_stddev_top #(
        .MAX_SAMPLES(MAX_BLOCK)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .sample  (sample),
        .last    (last),
        .valid   (valid),
        .mean    (mean),
        .variance(variance),
        .std_dev (std_dev),
        .count   (count),
        .status  (status)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // floor square root, one root bit per step
    function automatic logic [STD_BITS-1:0] floor_root(input longint v);
        logic [STD_BITS:0] root;
        logic [STD_BITS:0] trial;
        root = '0;
        for (int b = STD_BITS; b >= 0; b--)
        begin
            trial = root | ((STD_BITS+1)'(1) << b);
            if (longint'(trial) * longint'(trial) <= v)
                root = trial;
        end
        return root[STD_BITS-1:0];
    endfunction

    // close the running block: mean, unbiased variance, root, count, status
    function automatic block_stats_t close_block();
        block_stats_t r;
        longint       n;
        longint       q;
        longint       rem;
        longint       dev_sq;
        longint       corr;
        longint       var_q;
        n   = blk_n;
        q   = blk_sum / n;
        rem = blk_sum - q * n;
        if (rem < 0)
        begin
            q   = q - 1;
            rem = rem + n;
        end
        // round to nearest, ties toward plus infinity
        r.mean = SAMPLE_BITS'(q + ((2 * rem >= n) ? 1 : 0));
        var_q  = 0;
        if (n < 2)
            r.status = ST_SINGLE;
        else
        begin
            // exact sum of squared deviations is dev_sq - rem^2/n
            dev_sq = blk_sqsum - q * (blk_sum + rem);
            corr   = (rem * rem + n - 1) / n;
            if (dev_sq >= corr)
                var_q = (dev_sq - corr) / (n - 1);
            r.status = blk_over ? ST_OVER : ST_OK;
        end
        r.variance = VAR_BITS'(var_q);
        r.std_dev  = floor_root(var_q);
        r.count    = CNT_W'(blk_n);
        blk_sum    = 0;
        blk_sqsum  = 0;
        blk_n      = 0;
        blk_over   = 1'b0;
        return r;
    endfunction

    // failure bookkeeping, first ten are printed
    function automatic void note_error(input string msg);
        err_count++;
        if (err_count <= 10)
            $display("[%0t] mismatch: %s", $time, msg);
    endfunction

    function automatic void compare_field(input string name, input longint want,
                                          input longint got);
        if (want != got)
            note_error($sformatf("%s expected %0d got %0d", name, want, got));
    endfunction

    // send one sample beat, idling a random number of cycles first unless steady
    task automatic send_beat(input logic signed [SAMPLE_BITS-1:0] smp, input logic lst);
        while (!steady && $urandom_range(0, 99) < 37)
        begin
            start  <= 1'b0;
            sample <= SAMPLE_BITS'($urandom);
            last   <= 1'($urandom);
            @(posedge clk);
        end
        start  <= 1'b1;
        sample <= smp;
        last   <= lst;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        // beat taken: fold into the block, dropped once the limit is held
        if (blk_n < MAX_BLOCK)
        begin
            blk_sum   += longint'(smp);
            blk_sqsum += longint'(smp) * longint'(smp);
            blk_n++;
        end
        else
            blk_over = 1'b1;
        if (lst)
            pending_stats.push_back(close_block());
    endtask

    // result checker
    always @(posedge clk)
    begin
        block_stats_t want;
        if (rst_n && valid)
        begin
            if (pending_stats.size() == 0)
                note_error($sformatf("result with none expected, mean %0d count %0d",
                                     mean, count));
            else
            begin
                want = pending_stats.pop_front();
                compare_field("mean", want.mean, mean);
                compare_field("variance", want.variance, variance);
                compare_field("std_dev", want.std_dev, std_dev);
                compare_field("count", want.count, count);
                compare_field("status", longint'(want.status), status);
            end
        end
    end

    // one-sample blocks at the field extremes and at zero
    task automatic test_single_sample();
        send_beat(-16'sd32768, 1'b1);
        send_beat(16'sd32767, 1'b1);
        send_beat(16'sd0, 1'b1);
    endtask

    // extreme values: largest spread, flat blocks at each rail, alternating rails
    task automatic test_extremes();
        send_beat(16'sd32767, 1'b0);
        send_beat(-16'sd32768, 1'b1);
        send_beat(-16'sd32768, 1'b0);
        send_beat(-16'sd32768, 1'b1);
        send_beat(16'sd32767, 1'b0);
        send_beat(16'sd32767, 1'b0);
        send_beat(16'sd32767, 1'b1);
        for (int i = 0; i < 4; i++)
            send_beat((i % 2) ? 16'sd32767 : -16'sd32768, i == 3);
    endtask

    // mean ties and negative remainders
    task automatic test_mean_rounding();
        send_beat(16'sd1, 1'b0);
        send_beat(16'sd2, 1'b1);
        send_beat(-16'sd1, 1'b0);
        send_beat(-16'sd2, 1'b1);
        send_beat(-16'sd1, 1'b0);
        send_beat(16'sd0, 1'b0);
        send_beat(16'sd0, 1'b1);
    endtask

    // block that runs past the limit, its final beat dropped
    task automatic test_block_limit();
        for (int i = 0; i < MAX_BLOCK + 2; i++)
            send_beat(SAMPLE_BITS'($urandom), i == MAX_BLOCK + 1);
    endtask

    // random blocks of random length and content shape
    task automatic test_random_blocks();
        int sent;
        int len;
        int shape;
        int base;
        int pick;
        logic signed [SAMPLE_BITS-1:0] smp;
        sent = 0;
        while (sent < RANDOM_BEATS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                len = $urandom_range(1, 8);
            else if (pick < 95)
                len = $urandom_range(9, 64);
            else
                len = $urandom_range(65, 200);
            shape = $urandom_range(0, 4);
            base  = int'($urandom_range(0, 64000)) - 32000;
            // a stretch with the sender never idling
            steady = (sent > 150 && sent < 350);
            for (int i = 0; i < len; i++)
            begin
                case (shape)
                    0: smp = SAMPLE_BITS'($urandom);
                    1: smp = $urandom_range(0, 1) ? 16'sd32767 : -16'sd32768;
                    2: smp = SAMPLE_BITS'(base);
                    3: smp = SAMPLE_BITS'(base + int'($urandom_range(0, 6)) - 3);
                    default: smp = SAMPLE_BITS'(int'($urandom_range(0, 15)) - 8);
                endcase
                send_beat(smp, i == len - 1);
            end
            sent += len;
        end
        steady = 1'b0;
    endtask

    // main sequence
    initial
    begin
        rst_n     <= 1'b0;
        start     <= 1'b0;
        sample    <= '0;
        last      <= 1'b0;
        blk_sum   = 0;
        blk_sqsum = 0;
        blk_n     = 0;
        blk_over  = 1'b0;
        err_count = 0;
        steady    = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_single_sample();
        test_extremes();
        test_mean_rounding();
        test_block_limit();
        test_random_blocks();

        start <= 1'b0;
        while (pending_stats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
